/* sv/bcr_pkg.sv */
// ----------------------------------------------------------------------------
// bcr_pkg: shared types and constants of the stereo bitcrusher
// Sample, scale and product widths, reciprocal reset value, Q15 saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SCALE_W  = 16;
	localparam int PHASE_W  = 16;
	localparam int QUO_W    = 32;
	localparam int RECIP_W  = QUO_W + 1;
	localparam int MUL_B_W  = RECIP_W + 1;
	localparam int PROD_W   = SAMPLE_W + MUL_B_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [SCALE_W-1:0]  scale_t;
	typedef logic        [PHASE_W-1:0]  phase_t;
	typedef logic        [RECIP_W-1:0]  recip_t;
	typedef logic signed [MUL_B_W-1:0]  mul_b_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	// 2 * floor(2^31 / 65535)
	localparam recip_t RECIP_RESET = RECIP_W'(65536);
	localparam scale_t SCALE_RESET = 16'hFFFF;
	localparam phase_t RATE_RESET  = 16'h8000;

	localparam sample_t Q15_MAX = 16'sh7FFF;
	localparam sample_t Q15_MIN = -16'sh8000;

	localparam logic CFG_SCALE = 1'b0;
	localparam logic CFG_RATE  = 1'b1;

	// floor(p / 2^16) saturated to Q15
	function automatic sample_t sat_q15(input prod_t p);
		logic [PROD_W-32:0] top;
		sample_t res;
		top = p[PROD_W-1:31];
		if (top == '0 || top == '1) begin
			res = p[31:16];
		end else if (p[PROD_W-1]) begin
			res = Q15_MIN;
		end else begin
			res = Q15_MAX;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* sv/stereo_bitcrusher.sv */
// ----------------------------------------------------------------------------
// stereo_bitcrusher: amplitude quantizer with sample-rate reduction
// Sequencer around one shared multiplier and a bit-serial reciprocal divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one stereo Q15 pair per transfer.
//   Output channel (out_valid/out_stall) returns one held pair per input.
//   Config channel (cfg_valid/cfg_ready): index 0 = scale, 1 = rate_step.
//   A nonzero scale write starts a reciprocal computation; in_stall is high
//   and cfg_ready low until it finishes.
// Sequencing:
//   Pair without capture: from ST_IDLE to ST_OUT, which loads the output register.
//   Pair with capture: four products through the one multiplier in ST_MUL_XL,
//   ST_MUL_XR, ST_MUL_YL and ST_MUL_YR, the held pair taken in ST_MUL_YR and
//   ST_FIN, then ST_OUT. One pair is in work at a time; the next transfer is
//   taken once the result sits in the output register.
// Reset: phase and held samples clear, scale = 65535, rate_step = 32768.
// Stall: the output register holds its pair; the sequencer waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_bitcrusher import bcr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire sample_t left_in,
	input  wire sample_t right_in,
	output logic         out_valid,
	input  wire logic    out_stall,
	output sample_t      left_out,
	output sample_t      right_out,
	input  wire logic    cfg_valid,
	output logic         cfg_ready,
	input  wire logic    cfg_index,
	input  wire scale_t  cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL_XL = 3'd1;
	localparam logic [2:0] ST_MUL_XR = 3'd2;
	localparam logic [2:0] ST_MUL_YL = 3'd3;
	localparam logic [2:0] ST_MUL_YR = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0] state_q;
	scale_t     scale_q;
	phase_t     rate_q;
	phase_t     phase_q;
	sample_t    held_left_q, held_right_q;
	sample_t    x_left_q, x_right_q;
	sample_t    y_left_q, y_right_q;
	logic       out_valid_q;
	sample_t    left_out_q, right_out_q;

	logic       cfg_wr, scale_wr, recip_busy;
	recip_t     recip;
	logic       in_xfer, out_free;
	phase_t     phase_sum;
	sample_t    mul_a;
	mul_b_t     mul_b;
	prod_t      prod;

	assign cfg_ready = !recip_busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign scale_wr  = cfg_wr && (cfg_index == CFG_SCALE);
	assign in_stall  = (state_q != ST_IDLE) || recip_busy;
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign phase_sum = phase_q + rate_q;

	bcr_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scale_wr),
		.divisor (cfg_data),
		.busy    (recip_busy),
		.recip   (recip)
	);

	always_comb begin
		unique case (state_q)
			ST_MUL_XL: begin
				mul_a = x_left_q;
				mul_b = MUL_B_W'(scale_q);
			end
			ST_MUL_XR: begin
				mul_a = x_right_q;
				mul_b = MUL_B_W'(scale_q);
			end
			ST_MUL_YL: begin
				mul_a = y_left_q;
				mul_b = MUL_B_W'(recip);
			end
			default: begin
				mul_a = y_right_q;
				mul_b = MUL_B_W'(recip);
			end
		endcase
	end

	bcr_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			rate_q  <= RATE_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_SCALE) begin
				scale_q <= cfg_data;
			end else begin
				rate_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= '0;
			held_left_q  <= '0;
			held_right_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (phase_sum[PHASE_W-1]) begin
							phase_q <= {1'b0, phase_sum[PHASE_W-2:0]};
							state_q <= ST_MUL_XL;
						end else begin
							phase_q <= phase_sum;
							state_q <= ST_OUT;
						end
					end
				end
				ST_MUL_XL: state_q <= ST_MUL_XR;
				ST_MUL_XR: state_q <= ST_MUL_YL;
				ST_MUL_YL: state_q <= ST_MUL_YR;
				ST_MUL_YR: begin
					held_left_q <= sat_q15(prod);
					state_q     <= ST_FIN;
				end
				ST_FIN: begin
					held_right_q <= sat_q15(prod);
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_left_q  <= left_in;
			x_right_q <= right_in;
		end
		if (state_q == ST_MUL_XR) begin
			y_left_q <= prod[31:16];
		end
		if (state_q == ST_MUL_YL) begin
			y_right_q <= prod[31:16];
		end
		if (state_q == ST_OUT && out_free) begin
			left_out_q  <= held_left_q;
			right_out_q <= held_right_q;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		recip_busy |-> in_stall)
		else $error("input taken while reciprocal in progress");

	a_held_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MUL_YR) |=> $stable(held_left_q))
		else $error("held left changed outside its capture step");

	a_held_right: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> $stable(held_right_q))
		else $error("held right changed outside its capture step");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> out_valid_q && (state_q == ST_IDLE))
		else $error("result not loaded into output register");

endmodule

`default_nettype wire

/* sv/bcr_recip.sv */
// ----------------------------------------------------------------------------
// bcr_recip: reciprocal of the scale register
// Restoring divider, one quotient bit a cycle: recip = 2 * floor(2^31 / scale).
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_recip import bcr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire scale_t divisor,
	output logic        busy,
	output recip_t      recip
);

	localparam int CNT_W = $clog2(QUO_W);

	scale_t               div_q;
	scale_t               rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	recip_t               recip_q;

	logic [SCALE_W:0]     trial;
	logic                 ge;
	logic [QUO_W-1:0]     quo_next;

	always_comb begin
		trial    = {rem_q, (cnt_q == CNT_W'(QUO_W - 1))};
		ge       = trial >= {1'b0, div_q};
		quo_next = {quo_q[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			recip_q <= RECIP_RESET;
		end else if (start) begin
			if (divisor == '0) begin
				busy_q  <= 1'b0;
				recip_q <= '0;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q  <= 1'b0;
				recip_q <= {quo_next, 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? SCALE_W'(trial - {1'b0, div_q}) : trial[SCALE_W-1:0];
			quo_q <= quo_next;
		end
	end

	assign busy  = busy_q;
	assign recip = recip_q;

endmodule

`default_nettype wire

/* sv/bcr_mul.sv */
// ----------------------------------------------------------------------------
// bcr_mul: shared signed multiplier
// One product per cycle, registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_mul import bcr_pkg::*; (
	input  wire logic    clk,
	input  wire sample_t a,
	input  wire mul_b_t  b,
	output prod_t        prod
);

	prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

/* dv/crush_checker.sv */
// ----------------------------------------------------------------------------
// crush_checker: transfer monitor and scoreboard for the stereo bitcrusher
// Watches the input, output and register channels, tracks phase, held pair
// and register shadows, predicts each output pair and compares it in order.
// ----------------------------------------------------------------------------

module crush_checker import bcr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_stall,
	input  wire sample_t left_in,
	input  wire sample_t right_in,
	input  wire logic    out_valid,
	input  wire logic    out_stall,
	input  wire sample_t left_out,
	input  wire sample_t right_out,
	input  wire logic    cfg_valid,
	input  wire logic    cfg_ready,
	input  wire logic    cfg_index,
	input  wire scale_t  cfg_data,
	output int           mismatches,
	output int           outstanding,
	output int           compared,
	output int           captures
);

	typedef struct packed {
		sample_t left;
		sample_t right;
	} pair_t;

	scale_t  scale_q;
	phase_t  rate_q;
	phase_t  phase_q;
	sample_t hold_l;
	sample_t hold_r;
	pair_t   crushed_pairs[$];

	// floor(x*scale/2^16), times 2*floor(2^31/scale), floor /2^16, saturate
	function automatic sample_t crush_sample(input sample_t x, input scale_t s);
		longint xs;
		longint sc;
		longint y;
		longint rcp;
		longint q;
		xs = x;
		sc = s;
		y = (xs * sc) >>> 16;
		rcp = (s == '0) ? 64'sd0 : 2 * ((longint'(1) << 31) / sc);
		q = (y * rcp) >>> 16;
		if (q > longint'(Q15_MAX)) begin
			q = Q15_MAX;
		end else if (q < longint'(Q15_MIN)) begin
			q = Q15_MIN;
		end
		return sample_t'(q);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		phase_t sum;
		pair_t  want;
		if (!arst_n) begin
			scale_q     <= SCALE_RESET;
			rate_q      <= RATE_RESET;
			phase_q     <= '0;
			hold_l      <= '0;
			hold_r      <= '0;
			mismatches  <= 0;
			outstanding <= 0;
			compared    <= 0;
			captures    <= 0;
			crushed_pairs.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (crushed_pairs.size() == 0) begin
					if (mismatches < 10) begin
						$display("[%0t] unexpected output pair L=%0d R=%0d", $realtime,
							left_out, right_out);
					end
					mismatches <= mismatches + 1;
				end else begin
					want = crushed_pairs.pop_front();
					compared <= compared + 1;
					if (want.left !== left_out || want.right !== right_out) begin
						if (mismatches < 10) begin
							$display("[%0t] pair mismatch: exp L=%0d R=%0d, got L=%0d R=%0d",
								$realtime, want.left, want.right, left_out, right_out);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				sum = phase_q + rate_q;
				if (sum[PHASE_W-1]) begin
					sum[PHASE_W-1] = 1'b0;
					want.left  = crush_sample(left_in, scale_q);
					want.right = crush_sample(right_in, scale_q);
					hold_l   <= want.left;
					hold_r   <= want.right;
					captures <= captures + 1;
				end else begin
					want.left  = hold_l;
					want.right = hold_r;
				end
				phase_q <= sum;
				crushed_pairs.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SCALE) begin
					scale_q <= cfg_data;
				end else begin
					rate_q <= cfg_data;
				end
			end
			outstanding <= crushed_pairs.size();
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the stereo bitcrusher
// Directed pairs at the sample extremes and the corner register settings,
// then random pairs over several scale and rate settings, with random idle
// bursts on the input and output channels. Checking is in crush_checker.
// ----------------------------------------------------------------------------

module tb;
	import bcr_pkg::*;

	localparam int LIMIT  = 400000;
	localparam int LINGER = 10;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	sample_t left_in;
	sample_t right_in;
	logic    out_valid;
	logic    out_stall;
	sample_t left_out;
	sample_t right_out;
	logic    cfg_valid;
	logic    cfg_ready;
	logic    cfg_index;
	scale_t  cfg_data;

	int mismatches;
	int outstanding;
	int compared;
	int captures;
	int cycles;
	int n_pairs;
	int n_writes;
	bit quiet;

	stereo_bitcrusher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	crush_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_in     (left_in),
		.right_in    (right_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared),
		.captures    (captures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d pairs still pending", cycles, outstanding);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// output side back-pressure
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet) begin
				case ($urandom_range(0, 3))
					0: begin
						out_stall <= 1'b1;
						repeat ($urandom_range(1, 14)) @(posedge clk);
						out_stall <= 1'b0;
					end
					1: begin
						repeat ($urandom_range(10, 40)) @(posedge clk);
					end
					default: ;
				endcase
			end
		end
	end

	function automatic sample_t pick_sample();
		sample_t v;
		case ($urandom_range(0, 9))
			0:       v = Q15_MAX;
			1:       v = Q15_MIN;
			2:       v = '0;
			3:       v = -16'sd1;
			default: v = sample_t'($urandom);
		endcase
		return v;
	endfunction

	task automatic push_pair(input sample_t l, input sample_t r);
		in_valid <= 1'b1;
		left_in  <= l;
		right_in <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_pairs++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// hold off the sender until every pending pair has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (LINGER) @(posedge clk);
	endtask

	task automatic program_reg(input logic idx, input scale_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_writes++;
		@(posedge clk);
	endtask

	task automatic reprogram(input scale_t s, input phase_t r);
		settle();
		program_reg(CFG_SCALE, s);
		program_reg(CFG_RATE, r);
	endtask

	initial begin
		scale_t s;
		phase_t r;
		cycles    = 0;
		n_pairs   = 0;
		n_writes  = 0;
		quiet     = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		left_in   <= '0;
		right_in  <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SCALE;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: capture on every pair
		push_pair(Q15_MAX, Q15_MIN);
		push_pair(Q15_MIN, Q15_MAX);
		push_pair('0, '0);
		push_pair(-16'sd1, 16'sd1);
		push_pair(16'sh5555, 16'shAAAA);
		push_pair(16'shAAAA, 16'sh5555);

		// unit scale: negative samples saturate, the others give zero
		reprogram(16'd1, 16'h8000);
		push_pair(Q15_MAX, Q15_MIN);
		push_pair(-16'sd1, 16'sd1);
		push_pair(Q15_MIN, '0);

		// zero scale gives zero
		reprogram(16'd0, 16'h8000);
		push_pair(Q15_MAX, Q15_MIN);
		push_pair(16'sd1234, -16'sd4321);
		push_pair(Q15_MIN, Q15_MAX);

		// step above half: phase wraps
		reprogram(16'd40000, 16'hFFFF);
		push_pair(Q15_MAX, Q15_MIN);
		push_pair(16'sd20000, -16'sd20000);
		push_pair(Q15_MIN, Q15_MAX);
		push_pair(16'sd77, -16'sd77);

		// zero step: held pair repeats
		reprogram(16'd40000, 16'h0000);
		push_pair(Q15_MAX, Q15_MAX);
		push_pair(Q15_MIN, Q15_MIN);
		push_pair(16'sd5, -16'sd5);

		// coarse scale, fractional rate
		reprogram(16'd300, 16'd12345);
		push_pair(Q15_MAX, Q15_MIN);
		push_pair(16'sd1000, -16'sd1000);
		push_pair(16'sd32000, -16'sd32000);
		push_pair(-16'sd1, 16'sd1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					s = scale_t'($urandom_range(1, 65535));
					r = phase_t'($urandom_range(1, 32768));
				end
				1: begin s = 16'd1;                    r = 16'h8000;                 end
				2: begin
					s = scale_t'($urandom_range(1, 255));
					r = phase_t'($urandom_range(8192, 32768));
				end
				3: begin s = 16'hFFFF;                 r = 16'hFFFF;                 end
				4: begin
					s = scale_t'($urandom_range(1, 65535));
					r = 16'h0000;
				end
				5: begin
					s = 16'd0;
					r = phase_t'($urandom_range(1, 32768));
				end
				6: begin
					s = scale_t'($urandom_range(256, 65535));
					r = phase_t'($urandom_range(32769, 65535));
				end
				default: begin
					s = scale_t'($urandom_range(1, 65535));
					r = 16'h8000;
				end
			endcase
			reprogram(s, r);
			if (ph == 7) quiet = 1'b1;
			for (int i = 0; i < 112; i++) begin
				push_pair(pick_sample(), pick_sample());
				if (ph == 2 && i == 56) settle();
			end
		end

		settle();
		$display("covered %0d sample pairs (%0d captures) across %0d register writes",
			n_pairs, captures, n_writes);
		$display("%0d output pairs compared, %0d mismatches", compared, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
